// File: hdl/one_euro_filter_core_macros.svh
// Assertion macros for the one-euro filter core.
// Used by the RTL files that carry concurrent checks; needs signals clock and reset in scope.
`ifndef ONE_EURO_FILTER_CORE_MACROS_SVH
`define ONE_EURO_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define OEF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OEF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/oef_pkg.sv
// Shared types and constants for the one-euro filter core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package oef_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int STAMP_WIDTH_DEF  = 32;

   // 2*pi as unsigned Q4.28
   localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;

   // divider geometry
   localparam int DIV_W = 64;
   localparam int QUO_W = 36;
   localparam int CNT_W = 6;

   // 1e6 in Q.16
   localparam logic [QUO_W-1:0] RATE_NUM      = 36'd65536000000;
   localparam logic [CNT_W-1:0] RATE_DIV_STEPS  = 6'd36;
   localparam logic [CNT_W-1:0] ALPHA_DIV_STEPS = 6'd17;

   localparam logic [16:0] INIT_RATE_RST = 17'd120;
   localparam logic [15:0] MIN_CUT_RST   = 16'd256;
   localparam logic [15:0] GAIN_RST      = 16'd0;
   localparam logic [15:0] DCUT_RST      = 16'd256;

   typedef enum logic [1:0] {
      CSR_INIT_RATE = 2'd0,
      CSR_MIN_CUT   = 2'd1,
      CSR_GAIN      = 2'd2,
      CSR_DCUT      = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE,
      ST_RATE_DIV,
      ST_DMAG,
      ST_WMUL,
      ST_ADIV,
      ST_BLEND,
      ST_CUT,
      ST_DONE
   } oef_state_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem_init;
      logic [QUO_W-1:0] num;
      logic [CNT_W-1:0] count;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic [63:0] a;
      logic [31:0] b;
   } mul_req_type;

endpackage

// File: hdl/oef_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on oef_pkg.
`timescale 1ns / 1ps

module oef_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  oef_pkg::div_req_type         req,
   output logic                         done,
   output logic [oef_pkg::QUO_W-1:0]    quo
);
   import oef_pkg::*;

   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dsr_ff;
   logic [QUO_W-1:0] num_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= req.count;
            rem_ff <= req.rem_init;
            num_ff <= req.num;
            dsr_ff <= req.divisor;
            quo_ff <= '0;
         end else if (cnt_ff != '0) begin
            rem_ff <= fits ? DIV_W'(trial - {1'b0, dsr_ff}) : trial[DIV_W-1:0];
            num_ff <= {num_ff[QUO_W-2:0], 1'b0};
            quo_ff <= {quo_ff[QUO_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: hdl/oef_mul.sv
// 64x32 multiplier built from one registered 32x32 product over two passes.
// Depends on oef_pkg.
`timescale 1ns / 1ps

module oef_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  oef_pkg::mul_req_type req,
   output logic                 done,
   output logic [95:0]          prod
);
   import oef_pkg::*;

   logic [63:0] a_ff;
   logic [31:0] b_ff;
   logic [63:0] part_ff;
   logic [95:0] acc_ff;
   logic [1:0]  phase_ff;
   logic        done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            2'd0: begin
               if (start) begin
                  a_ff     <= req.a;
                  b_ff     <= req.b;
                  phase_ff <= 2'd1;
               end
            end
            2'd1: begin
               part_ff  <= a_ff[31:0] * b_ff;
               phase_ff <= 2'd2;
            end
            2'd2: begin
               part_ff  <= a_ff[63:32] * b_ff;
               acc_ff   <= 96'(part_ff);
               phase_ff <= 2'd3;
            end
            default: begin
               acc_ff   <= acc_ff + {part_ff, 32'h0};
               done_ff  <= 1'b1;
               phase_ff <= 2'd0;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// File: hdl/one_euro_filter_core.sv
// One-euro adaptive low-pass filter, top level with sequencer and state.
// Depends on oef_pkg, oef_div, oef_mul and one_euro_filter_core_macros.svh.
//
// Usage:
//   req channel: one word per sample; req_tdata = {time_stamp, sample}
//   (sample in the low 32 bits), req_tuser = stamp_valid.
//   rsp channel: one word per accepted sample, rsp_tdata = smoothed.
//   csr port: csr_wr_en/csr_index/csr_wdata write initial_rate (0),
//   min_cutoff (1), speed_gain (2), deriv_cutoff (3); write only while idle.
//   Writing initial_rate also reloads the working rate.
// Sequencing:
//   The first sample takes the shortest path to rsp_tvalid; later samples take
//   longer, and longest when a timestamp pair updates the rate (shorter when an
//   alpha saturates). Path lengths are set by the shared serial divider (for the
//   rate and each alpha) and the two-pass multiplier.
//   req_tready is high only while the sequencer is idle, so a new sample is
//   taken only after the sequencer has finished the previous one.
// Reset clears all filter state and loads register defaults. A stalled
// result stays in the output register; the next sample is accepted, and its
// result waits for the previous one to be taken.
`timescale 1ns / 1ps
`include "one_euro_filter_core_macros.svh"

module one_euro_filter_core #(
   parameter int SAMPLE_WIDTH = oef_pkg::SAMPLE_WIDTH_DEF,
   parameter int STAMP_WIDTH  = oef_pkg::STAMP_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // sample[31:0], time_stamp[63:32]
   input  logic        req_tuser,   // stamp_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // smoothed[31:0]
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import oef_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int TW = STAMP_WIDTH;
   localparam logic [SW-2:0] LIM = '1;

   oef_state_type state_ff, state_in;

   logic signed [SW-1:0] x_ff, x_in, tgt_ff, tgt_in, last_raw_ff, last_raw_in;
   logic signed [SW-1:0] value_ff, value_in, deriv_ff, deriv_in, y_ff, y_in;
   logic [TW-1:0] ts_ff, ts_in, prev_stamp_ff, prev_stamp_in, diff_ff, diff_in;
   logic          sv_ff, sv_in, prev_valid_ff, prev_valid_in;
   logic [31:0]   rate_ff, rate_in, cut_ff, cut_in, rsp_data_ff, rsp_data_in;
   logic [42:0]   w_ff, w_in;
   logic [16:0]   alpha_ff, alpha_in;
   logic          pass_ff, pass_in, primed_ff, primed_in, busy_ff, busy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [16:0]   init_rate_ff, init_rate_in;
   logic [15:0]   min_cut_ff, min_cut_in, gain_ff, gain_in, dcut_ff, dcut_in;

   logic        mul_start, mul_done, div_start, div_done;
   logic [95:0] mul_p;
   logic [QUO_W-1:0] div_q;
   mul_req_type mul_req;
   div_req_type div_req;

   logic signed [SW:0] d_diff, b_diff;
   logic [SW:0]        d_mag, b_mag, step, res_w;
   logic [SW-1:0]      e_mag;
   logic signed [SW-1:0] base, dv, blend_res;
   logic [SW-2:0]      dm;
   logic [95:0]        p_rnd;
   logic [43:0]        den;
   logic [63:0]        cut_sum;
   logic [31:0]        cut_sel, cut_sat, rate_q, init_rate_q, y_sat;
   logic [TW-1:0]      diff_now;
   logic signed [63:0] y64;

   assign d_diff = {x_ff[SW-1], x_ff} - {last_raw_ff[SW-1], last_raw_ff};
   assign d_mag  = d_diff[SW] ? (SW+1)'(-d_diff) : d_diff;
   assign dm     = (mul_p[95:16] > 80'(LIM)) ? LIM : mul_p[SW+14:16];
   assign dv     = d_diff[SW] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});

   assign base   = pass_ff ? value_ff : deriv_ff;
   assign b_diff = {tgt_ff[SW-1], tgt_ff} - {base[SW-1], base};
   assign b_mag  = b_diff[SW] ? (SW+1)'(-b_diff) : b_diff;
   assign p_rnd  = mul_p + 96'h8000;
   assign step   = (SW+1)'(p_rnd[95:16]);
   assign res_w  = b_diff[SW] ? ({base[SW-1], base} - step) : ({base[SW-1], base} + step);
   assign blend_res = res_w[SW-1:0];

   assign e_mag   = deriv_ff[SW-1] ? SW'(-deriv_ff) : deriv_ff;
   assign den     = {1'b0, w_ff} + 44'(rate_ff);
   assign cut_sel = pass_ff ? cut_ff : {8'h00, dcut_ff, 8'h00};
   assign cut_sum = 64'({min_cut_ff, 8'h00}) + mul_p[79:16];
   assign cut_sat = (cut_sum[63:32] != '0) ? 32'hFFFF_FFFF : cut_sum[31:0];
   assign rate_q  = (div_q[QUO_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
   assign diff_now = ts_ff - prev_stamp_ff;

   // initial_rate in Q16.16, saturated
   assign init_rate_q = csr_wdata[16] ? 32'hFFFF_FFFF : {csr_wdata[15:0], 16'h0};

   assign y64   = 64'(y_ff);
   assign y_sat = (y64 > 64'sd2147483647)  ? 32'h7FFF_FFFF :
                  (y64 < -64'sd2147483648) ? 32'h8000_0000 : y64[31:0];

   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         ST_DMAG:  mul_req = '{a: 64'(d_mag), b: rate_ff};
         ST_WMUL:  mul_req = '{a: 64'(TWO_PI_Q28), b: cut_sel};
         ST_BLEND: mul_req = '{a: 64'(b_mag), b: 32'(alpha_ff)};
         ST_CUT:   mul_req = '{a: 64'(e_mag), b: 32'(gain_ff)};
         default:  mul_req = '0;
      endcase
   end

   always_comb begin
      if (state_ff == ST_RATE_DIV) begin
         div_req = '{rem_init: '0, num: RATE_NUM, count: RATE_DIV_STEPS,
                     divisor: 64'(diff_ff)};
      end else begin
         div_req = '{rem_init: 64'(w_ff[42:1]), num: {w_ff[0], 35'h0},
                     count: ALPHA_DIV_STEPS, divisor: 64'(den)};
      end
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      tgt_in        = tgt_ff;
      last_raw_in   = last_raw_ff;
      value_in      = value_ff;
      deriv_in      = deriv_ff;
      y_in          = y_ff;
      ts_in         = ts_ff;
      sv_in         = sv_ff;
      prev_stamp_in = prev_stamp_ff;
      prev_valid_in = prev_valid_ff;
      diff_in       = diff_ff;
      rate_in       = rate_ff;
      cut_in        = cut_ff;
      w_in          = w_ff;
      alpha_in      = alpha_ff;
      pass_in       = pass_ff;
      primed_in     = primed_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      init_rate_in  = init_rate_ff;
      min_cut_in    = min_cut_ff;
      gain_in       = gain_ff;
      dcut_in       = dcut_ff;
      mul_start     = 1'b0;
      div_start     = 1'b0;
      req_tready    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INIT_RATE: begin
               init_rate_in = csr_wdata;
               rate_in      = init_rate_q;
            end
            CSR_MIN_CUT: min_cut_in = csr_wdata[15:0];
            CSR_GAIN:    gain_in    = csr_wdata[15:0];
            CSR_DCUT:    dcut_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x_in     = $signed(SW'(req_tdata[31:0]));
               ts_in    = TW'(req_tdata[63:32]);
               sv_in    = req_tuser;
               pass_in  = 1'b0;
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            diff_in       = diff_now;
            prev_stamp_in = sv_ff ? ts_ff : '0;
            prev_valid_in = sv_ff;
            if (sv_ff && prev_valid_ff && (diff_now != '0)) begin
               state_in = ST_RATE_DIV;
            end else if (primed_ff) begin
               state_in = ST_DMAG;
            end else begin
               deriv_in = '0;
               state_in = ST_CUT;
            end
         end
         ST_RATE_DIV: begin
            if (!busy_ff) begin
               div_start = 1'b1;
               busy_in   = 1'b1;
            end else if (div_done) begin
               busy_in = 1'b0;
               rate_in = rate_q;
               if (primed_ff) begin
                  state_in = ST_DMAG;
               end else begin
                  deriv_in = '0;
                  state_in = ST_CUT;
               end
            end
         end
         ST_DMAG: begin
            if (!busy_ff) begin
               mul_start = 1'b1;
               busy_in   = 1'b1;
            end else if (mul_done) begin
               busy_in  = 1'b0;
               tgt_in   = dv;
               state_in = ST_WMUL;
            end
         end
         ST_WMUL: begin
            if (!busy_ff) begin
               mul_start = 1'b1;
               busy_in   = 1'b1;
            end else if (mul_done) begin
               busy_in  = 1'b0;
               w_in     = mul_p[62:20];
               state_in = ST_ADIV;
            end
         end
         ST_ADIV: begin
            if (den == '0) begin
               alpha_in = 17'h10000;
               state_in = ST_BLEND;
            end else if (!busy_ff) begin
               div_start = 1'b1;
               busy_in   = 1'b1;
            end else if (div_done) begin
               busy_in  = 1'b0;
               alpha_in = (div_q[16:0] == '0) ? 17'd1 : div_q[16:0];
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            // full-strength alpha passes the target through
            if (alpha_ff[16]) begin
               if (pass_ff) begin
                  y_in     = tgt_ff;
                  state_in = ST_DONE;
               end else begin
                  deriv_in = tgt_ff;
                  state_in = ST_CUT;
               end
            end else if (!busy_ff) begin
               mul_start = 1'b1;
               busy_in   = 1'b1;
            end else if (mul_done) begin
               busy_in = 1'b0;
               if (pass_ff) begin
                  y_in     = blend_res;
                  state_in = ST_DONE;
               end else begin
                  deriv_in = blend_res;
                  state_in = ST_CUT;
               end
            end
         end
         ST_CUT: begin
            if (!busy_ff) begin
               mul_start = 1'b1;
               busy_in   = 1'b1;
            end else if (mul_done) begin
               busy_in = 1'b0;
               cut_in  = cut_sat;
               if (primed_ff) begin
                  pass_in  = 1'b1;
                  tgt_in   = x_ff;
                  state_in = ST_WMUL;
               end else begin
                  y_in     = x_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_sat;
               value_in     = y_ff;
               last_raw_in  = x_ff;
               primed_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_raw_ff   <= '0;
         value_ff      <= '0;
         deriv_ff      <= '0;
         prev_stamp_ff <= '0;
         prev_valid_ff <= 1'b0;
         primed_ff     <= 1'b0;
         busy_ff       <= 1'b0;
         pass_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rate_ff       <= {INIT_RATE_RST[15:0], 16'h0};
         init_rate_ff  <= INIT_RATE_RST;
         min_cut_ff    <= MIN_CUT_RST;
         gain_ff       <= GAIN_RST;
         dcut_ff       <= DCUT_RST;
      end else begin
         state_ff      <= state_in;
         last_raw_ff   <= last_raw_in;
         value_ff      <= value_in;
         deriv_ff      <= deriv_in;
         prev_stamp_ff <= prev_stamp_in;
         prev_valid_ff <= prev_valid_in;
         primed_ff     <= primed_in;
         busy_ff       <= busy_in;
         pass_ff       <= pass_in;
         rsp_valid_ff  <= rsp_valid_in;
         rate_ff       <= rate_in;
         init_rate_ff  <= init_rate_in;
         min_cut_ff    <= min_cut_in;
         gain_ff       <= gain_in;
         dcut_ff       <= dcut_in;
      end
      x_ff        <= x_in;
      tgt_ff      <= tgt_in;
      y_ff        <= y_in;
      ts_ff       <= ts_in;
      sv_ff       <= sv_in;
      diff_ff     <= diff_in;
      cut_ff      <= cut_in;
      w_ff        <= w_in;
      alpha_ff    <= alpha_in;
      rsp_data_ff <= rsp_data_in;
   end

   oef_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .req   (mul_req),
      .done  (mul_done),
      .prod  (mul_p)
   );

   oef_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `OEF_ASSERT_IMP(a_one_unit, 1'b1, !(mul_start && div_start), "both units started")
   `OEF_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `OEF_ASSERT_IMP(a_idle_not_busy, state_ff == ST_IDLE, !busy_ff, "unit busy while idle")
   `OEF_ASSERT_IMP(a_alpha_nonzero, state_ff == ST_BLEND, alpha_ff != '0, "zero alpha in blend")

endmodule
